### design/aqi_pkg.sv
package aqi_pkg;

  // Breakpoint table: two pollutants, six segments each
  localparam int SEG_MAX   = 6;
  localparam int SEG_IDX_W = 3;
  localparam int CONC_W    = 15;
  localparam int IDX_W     = 9;
  localparam int CAT_W     = 3;
  localparam int MODE_W    = 1;

  // Reciprocal scaling: floor(num / (2*dc)) == (num * ceil(2^S / (2*dc))) >> S
  // is exact for every numerator the table can produce with S = 32.
  localparam int              RECIP_S   = 32;
  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_S;

  localparam logic [IDX_W-1:0] IDX_MAX = 9'd500;

  typedef enum logic [CAT_W-1:0] {
    CAT_GOOD,
    CAT_MODERATE,
    CAT_SENSITIVE,
    CAT_UNHEALTHY,
    CAT_VERY_UNHEALTHY,
    CAT_HAZARDOUS
  } category_t;

  localparam logic [MODE_W-1:0] MODE_PM25 = 1'b0;
  localparam logic [MODE_W-1:0] MODE_PM10 = 1'b1;

  typedef struct packed {
    logic                 hit;
    logic [SEG_IDX_W-1:0] seg;
  } seg_sel_t;

  // Bounds in tenths of ug/m3
  localparam logic signed [15:0] SEG_C_LO [2][SEG_MAX] = '{
    '{16'sd0, 16'sd91,  16'sd355,  16'sd555,  16'sd1255, 16'sd2255},
    '{16'sd0, 16'sd550, 16'sd1550, 16'sd2550, 16'sd3550, 16'sd4250}
  };

  localparam logic signed [15:0] SEG_C_HI [2][SEG_MAX] = '{
    '{16'sd90,  16'sd354,  16'sd554,  16'sd1254, 16'sd2254, 16'sd3254},
    '{16'sd540, 16'sd1540, 16'sd2540, 16'sd3540, 16'sd4240, 16'sd6040}
  };

  localparam logic [IDX_W-1:0] SEG_I_LO [2][SEG_MAX] = '{
    '{9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301},
    '{9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301}
  };

  // Slope term: 2*di * ceil(2^S / (2*dc))
  localparam logic [31:0] SEG_MUL [2][SEG_MAX] = '{
    '{32'(64'd100 * ((RECIP_ONE + 64'd179)  / 64'd180)),
      32'(64'd98  * ((RECIP_ONE + 64'd525)  / 64'd526)),
      32'(64'd98  * ((RECIP_ONE + 64'd397)  / 64'd398)),
      32'(64'd98  * ((RECIP_ONE + 64'd1397) / 64'd1398)),
      32'(64'd198 * ((RECIP_ONE + 64'd1997) / 64'd1998)),
      32'(64'd398 * ((RECIP_ONE + 64'd1997) / 64'd1998))},
    '{32'(64'd100 * ((RECIP_ONE + 64'd1079) / 64'd1080)),
      32'(64'd98  * ((RECIP_ONE + 64'd1979) / 64'd1980)),
      32'(64'd98  * ((RECIP_ONE + 64'd1979) / 64'd1980)),
      32'(64'd98  * ((RECIP_ONE + 64'd1979) / 64'd1980)),
      32'(64'd198 * ((RECIP_ONE + 64'd1379) / 64'd1380)),
      32'(64'd398 * ((RECIP_ONE + 64'd3579) / 64'd3580))}
  };

  // Rounding term: dc * ceil(2^S / (2*dc))
  localparam logic [31:0] SEG_ADD [2][SEG_MAX] = '{
    '{32'(64'd90  * ((RECIP_ONE + 64'd179)  / 64'd180)),
      32'(64'd263 * ((RECIP_ONE + 64'd525)  / 64'd526)),
      32'(64'd199 * ((RECIP_ONE + 64'd397)  / 64'd398)),
      32'(64'd699 * ((RECIP_ONE + 64'd1397) / 64'd1398)),
      32'(64'd999 * ((RECIP_ONE + 64'd1997) / 64'd1998)),
      32'(64'd999 * ((RECIP_ONE + 64'd1997) / 64'd1998))},
    '{32'(64'd540  * ((RECIP_ONE + 64'd1079) / 64'd1080)),
      32'(64'd990  * ((RECIP_ONE + 64'd1979) / 64'd1980)),
      32'(64'd990  * ((RECIP_ONE + 64'd1979) / 64'd1980)),
      32'(64'd990  * ((RECIP_ONE + 64'd1979) / 64'd1980)),
      32'(64'd690  * ((RECIP_ONE + 64'd1379) / 64'd1380)),
      32'(64'd1790 * ((RECIP_ONE + 64'd3579) / 64'd3580))}
  };

endpackage

### design/aqi_seg_sel.sv
module aqi_seg_sel
  import aqi_pkg::*;
#(
  parameter int SEGMENTS = 6
) (
  input  logic                     mode,
  input  logic signed [CONC_W-1:0] conc,
  output seg_sel_t                 sel
);

  localparam int NSEG = (SEGMENTS < SEG_MAX) ? SEGMENTS : SEG_MAX;

  logic signed [15:0] conc_ext;
  logic [NSEG-1:0]    le;

  assign conc_ext = 16'(conc);

  always_comb begin
    for (int i = 0; i < NSEG; i++) begin
      le[i] = (conc_ext <= SEG_C_HI[mode][i]);
    end
  end

  // First segment whose upper bound covers the sample
  always_comb begin
    sel.hit = 1'b0;
    sel.seg = '0;
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (le[i]) begin
        sel.hit = 1'b1;
        sel.seg = SEG_IDX_W'(i);
      end
    end
  end

endmodule

### design/aqi_interp.sv
module aqi_interp
  import aqi_pkg::*;
(
  input  logic                     mode,
  input  logic signed [CONC_W-1:0] conc,
  input  seg_sel_t                 sel,
  output logic [IDX_W-1:0]         aqi_index,
  output category_t                category,
  output logic                     invalid
);

  logic signed [15:0] conc_ext;
  logic signed [15:0] diff;
  logic signed [11:0] ofs;
  logic signed [44:0] prod;
  logic signed [44:0] acc;
  logic [7:0]         quo;
  logic [IDX_W-1:0]   i_lo;
  logic [IDX_W-1:0]   seg_idx;

  assign conc_ext = 16'(conc);
  assign diff     = conc_ext - SEG_C_LO[mode][sel.seg];
  // Offset stays within -9 .. 1790 for every non-negative sample that hits a segment
  assign ofs      = diff[11:0];
  assign i_lo     = SEG_I_LO[mode][sel.seg];

  assign prod = 45'(signed'({1'b0, SEG_MUL[mode][sel.seg]})) * 45'(ofs);
  assign acc  = prod + 45'(signed'({1'b0, SEG_ADD[mode][sel.seg]}));
  assign quo  = acc[RECIP_S+7:RECIP_S];

  // A negative numerator only arises in a gap just below a segment, and it is
  // always smaller in magnitude than the divisor: the floor is minus one.
  assign seg_idx = acc[44] ? (i_lo - 9'd1) : (i_lo + IDX_W'(quo));

  always_comb begin
    invalid   = 1'b0;
    aqi_index = IDX_MAX;
    if (conc[CONC_W-1]) begin
      invalid   = 1'b1;
      aqi_index = '0;
    end else if (sel.hit) begin
      aqi_index = seg_idx;
    end
  end

  always_comb begin
    if (aqi_index <= 9'd50) begin
      category = CAT_GOOD;
    end else if (aqi_index <= 9'd100) begin
      category = CAT_MODERATE;
    end else if (aqi_index <= 9'd150) begin
      category = CAT_SENSITIVE;
    end else if (aqi_index <= 9'd200) begin
      category = CAT_UNHEALTHY;
    end else if (aqi_index <= 9'd300) begin
      category = CAT_VERY_UNHEALTHY;
    end else begin
      category = CAT_HAZARDOUS;
    end
  end

endmodule

### design/aqi_piecewise_linear_index.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   in_mode, in_concentration_tenths
// out_     output     out_valid/out_stall out_aqi_index, out_category, out_invalid
//
// One transaction per cycle sustained while out_stall is low; an accepted
// sample passes the input register, then the result register, to out_valid.
// The segment compare, one 33x12 reciprocal multiply and the category
// decode sit between the two registers and set the cycle time.
// rst_n is synchronous, active low, and clears both valid flags.
// A stalled result holds; the input register still loads while the result
// register is free or draining, so in_stall rises only when both are full.
module aqi_piecewise_linear_index
  import aqi_pkg::*;
#(
  parameter int SEGMENTS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic signed [CONC_W-1:0] in_concentration_tenths,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_aqi_index,
  output logic [CAT_W-1:0]         out_category,
  output logic                     out_invalid
);

  logic                     s1_valid_r;
  logic                     s1_mode_r;
  logic signed [CONC_W-1:0] s1_conc_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_aqi_index_r;
  logic [CAT_W-1:0]         out_category_r;
  logic                     out_invalid_r;

  logic                     out_free;
  logic                     in_take;
  seg_sel_t                 sel;
  logic [IDX_W-1:0]         aqi_index_nxt;
  category_t                category_nxt;
  logic                     invalid_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  aqi_seg_sel #(
    .SEGMENTS(SEGMENTS)
  ) u_seg_sel (
    .mode (s1_mode_r),
    .conc (s1_conc_r),
    .sel  (sel)
  );

  aqi_interp u_interp (
    .mode      (s1_mode_r),
    .conc      (s1_conc_r),
    .sel       (sel),
    .aqi_index (aqi_index_nxt),
    .category  (category_nxt),
    .invalid   (invalid_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (out_free || !s1_valid_r) begin
        s1_valid_r <= in_take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode;
      s1_conc_r <= in_concentration_tenths;
    end
    // Advance the result only when the downstream side can take it
    if (out_free && s1_valid_r) begin
      out_aqi_index_r <= aqi_index_nxt;
      out_category_r  <= category_nxt;
      out_invalid_r   <= invalid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_aqi_index = out_aqi_index_r;
  assign out_category  = out_category_r;
  assign out_invalid   = out_invalid_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_aqi_index == '0 && out_category == CAT_GOOD)
    else $error("invalid result carries nonzero index or category");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_aqi_index == IDX_MAX |-> out_category == CAT_HAZARDOUS)
    else $error("saturated index not hazardous");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid)
    else $error("input stage transaction lost on advance");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

endmodule
